// File: rtl/core/nfre_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfre_pkg - shared types and codes for the NOR flash RAM emulator
// Command and status codes, the erased byte value and the result record
// that passes from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package nfre_pkg;

    // Command codes carried on the request channel
    typedef enum logic [1:0] {
        CMD_MAP     = 2'd0,
        CMD_ERASE   = 2'd1,
        CMD_PROGRAM = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    // Status codes returned with every result
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_WINDOW = 2'd1,
        ST_BITS   = 2'd2,
        ST_END    = 2'd3
    } status_t;

    // Value of an erased flash byte
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // Width of the byte address field on the request channel
    localparam int unsigned BYTE_ADDR_W = 20;

    // One result on its way to the output stage
    typedef struct packed {
        status_t    status;
        logic [7:0] rdata;
    } res_t;

endpackage : nfre_pkg
`default_nettype wire

// File: rtl/core/nor_flash_ram_emulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nor_flash_ram_emulator - NOR flash modelled in a byte memory
// Map, erase, program and read requests with one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with cmd, block_index, window_index,
//   byte_address and program_byte; a request is taken when in_valid is high
//   and in_stall is low. Each request yields one result (status, read_byte)
//   on out_valid/out_stall, taken when out_valid is high and out_stall low.
//   Map, program and read reach the output register through the access step:
//   the byte read from the store is issued at the accepting edge, and the
//   checks and the write back follow in the access step. A successful erase
//   then walks the block, one store write per byte. One request is in
//   flight at a time, so a new request is not taken until the last one's
//   result has left the sequencer.
//   The result waits in an output register; the next request is accepted
//   while it waits. If the receiver keeps stalling, the following result
//   is held inside and in_stall stays high until the register drains.
//   Reset clears the window base to zero and empties the output; the store
//   contents are undefined until erased or programmed.
// ----------------------------------------------------------------------------
module nor_flash_ram_emulator #(
    parameter int unsigned TOTAL_BYTES  = 1048576,
    parameter int unsigned BLOCK_BYTES  = 8192,
    parameter int unsigned WINDOW_BYTES = 8192
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [1:0]                       cmd,
    input  wire logic [6:0]                       block_index,
    input  wire logic [6:0]                       window_index,
    input  wire logic [nfre_pkg::BYTE_ADDR_W-1:0] byte_address,
    input  wire logic [7:0]                       program_byte,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [1:0]                            status,
    output logic [7:0]                            read_byte
);

    localparam int unsigned ADDR_W = $clog2(TOTAL_BYTES);

    logic              res_valid;
    logic              res_take;
    nfre_pkg::res_t    res;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_ren;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg;
    logic [7:0]        read_byte_reg;

    nfre_seq #(
        .TOTAL_BYTES  (TOTAL_BYTES),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .WINDOW_BYTES (WINDOW_BYTES),
        .ADDR_W       (ADDR_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .block_index  (block_index),
        .window_index (window_index),
        .byte_address (byte_address),
        .program_byte (program_byte),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_ren      (mem_ren),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    nfre_mem #(
        .DEPTH  (TOTAL_BYTES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .ren   (mem_ren),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Load the output register when it is empty or being drained
    assign res_take       = !out_valid_reg || !out_stall;
    assign out_valid_next = (res_valid && res_take) || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            status_reg    <= res.status;
            read_byte_reg <= res.rdata;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign read_byte = read_byte_reg;

endmodule : nor_flash_ram_emulator
`default_nettype wire

// File: rtl/core/nfre_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfre_mem - flash byte store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module nfre_mem #(
    parameter int unsigned DEPTH  = 1048576,
    parameter int unsigned ADDR_W = 20
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic              ren,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [7:0]        rdata
);

    logic [7:0] store [DEPTH];

    // Write the byte
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata <= store[raddr];
        end
    end

endmodule : nfre_mem
`default_nettype wire

// File: rtl/core/nfre_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfre_seq - request sequencer
// Takes one request at a time, reads the addressed byte, checks range,
// window and bit rules, writes back programmed bytes and walks erases.
// ----------------------------------------------------------------------------
module nfre_seq #(
    parameter int unsigned TOTAL_BYTES  = 1048576,
    parameter int unsigned BLOCK_BYTES  = 8192,
    parameter int unsigned WINDOW_BYTES = 8192,
    parameter int unsigned ADDR_W       = 20
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // request side
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          cmd,
    input  wire logic [6:0]                          block_index,
    input  wire logic [6:0]                          window_index,
    input  wire logic [nfre_pkg::BYTE_ADDR_W-1:0]    byte_address,
    input  wire logic [7:0]                          program_byte,
    // result side
    output logic                                     res_valid,
    input  wire logic                                res_take,
    output nfre_pkg::res_t                           res,
    // memory
    output logic                                     mem_we,
    output logic [ADDR_W-1:0]                        mem_waddr,
    output logic [7:0]                               mem_wdata,
    output logic                                     mem_ren,
    output logic [ADDR_W-1:0]                        mem_raddr,
    input  wire logic [7:0]                          mem_rdata
);

    localparam int unsigned CNT_W   = $clog2(BLOCK_BYTES);
    localparam int unsigned WIDE_W  = (ADDR_W > nfre_pkg::BYTE_ADDR_W) ?
                                      ADDR_W : nfre_pkg::BYTE_ADDR_W;
    localparam int unsigned CMP_W   = WIDE_W + 2;
    localparam int unsigned BLK_LW  = $clog2(BLOCK_BYTES + 1);
    localparam int unsigned WIN_LW  = $clog2(WINDOW_BYTES + 1);
    localparam int unsigned TOT_LW  = $clog2(TOTAL_BYTES + 1);
    localparam int unsigned MAX_LW  = (BLK_LW > WIN_LW) ?
                                      ((BLK_LW > TOT_LW) ? BLK_LW : TOT_LW) :
                                      ((WIN_LW > TOT_LW) ? WIN_LW : TOT_LW);
    localparam int unsigned MAP_W   = MAX_LW + 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCESS,
        S_ERASE,
        S_HOLD
    } state_t;

    state_t                          state_reg, state_next;
    nfre_pkg::cmd_t                  cmd_reg;
    logic [6:0]                      blk_reg;
    logic [6:0]                      win_reg;
    logic [nfre_pkg::BYTE_ADDR_W-1:0] addr_reg;
    logic [7:0]                      val_reg;
    logic [ADDR_W-1:0]               window_base_reg, window_base_next;
    logic [ADDR_W-1:0]               ers_addr_reg, ers_addr_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    nfre_pkg::res_t                  hold_reg, hold_next;

    logic                            accept;
    logic [CMP_W-1:0]                addr_w;
    logic [CMP_W-1:0]                base_w;
    logic                            end_fail;
    logic                            win_fail;
    logic                            bit_fail;
    logic                            erase_fail;
    logic [MAP_W-1:0]                map_base;
    logic                            map_fail;
    logic                            erase_start;
    logic                            cnt_last;
    nfre_pkg::res_t                  res_now;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    // Issue the byte read with the request
    assign mem_ren   = accept;
    assign mem_raddr = ADDR_W'(byte_address);

    // Range, window and bit checks on the captured request
    assign addr_w     = CMP_W'(addr_reg);
    assign base_w     = CMP_W'(window_base_reg);
    assign end_fail   = addr_w >= CMP_W'(TOTAL_BYTES);
    assign win_fail   = (addr_w < base_w) || (addr_w >= base_w + CMP_W'(WINDOW_BYTES));
    assign bit_fail   = |(~mem_rdata & val_reg);
    assign erase_fail = (base_w + CMP_W'(BLOCK_BYTES)) > CMP_W'(TOTAL_BYTES);
    assign map_base   = MAP_W'(blk_reg) * MAP_W'(BLOCK_BYTES)
                      + MAP_W'(win_reg) * MAP_W'(WINDOW_BYTES);
    assign map_fail   = map_base >= MAP_W'(TOTAL_BYTES);
    assign cnt_last   = (cnt_reg == CNT_W'(BLOCK_BYTES - 1));

    // Form the result of the current request
    always_comb
    begin
        res_now.status = nfre_pkg::ST_OK;
        res_now.rdata  = 8'h00;
        if (state_reg == S_ACCESS)
        begin
            unique case (cmd_reg)
                nfre_pkg::CMD_MAP:
                begin
                    if (map_fail)
                    begin
                        res_now.status = nfre_pkg::ST_END;
                    end
                end
                nfre_pkg::CMD_ERASE:
                begin
                    if (erase_fail)
                    begin
                        res_now.status = nfre_pkg::ST_END;
                    end
                end
                nfre_pkg::CMD_PROGRAM:
                begin
                    if (end_fail)
                    begin
                        res_now.status = nfre_pkg::ST_END;
                    end
                    else if (win_fail)
                    begin
                        res_now.status = nfre_pkg::ST_WINDOW;
                    end
                    else if (bit_fail)
                    begin
                        res_now.status = nfre_pkg::ST_BITS;
                    end
                end
                nfre_pkg::CMD_READ:
                begin
                    if (end_fail)
                    begin
                        res_now.status = nfre_pkg::ST_END;
                    end
                    else
                    begin
                        res_now.rdata = mem_rdata;
                    end
                end
                default:
                begin
                    res_now.status = nfre_pkg::ST_OK;
                end
            endcase
        end
    end

    assign erase_start = (state_reg == S_ACCESS) && (cmd_reg == nfre_pkg::CMD_ERASE)
                         && !erase_fail;
    assign res_valid   = ((state_reg == S_ACCESS) && !erase_start)
                         || ((state_reg == S_ERASE) && cnt_last)
                         || (state_reg == S_HOLD);
    assign res         = (state_reg == S_HOLD) ? hold_reg : res_now;

    // Write back a programmed byte, or fill the block during an erase
    assign mem_we    = (state_reg == S_ERASE)
                       || ((state_reg == S_ACCESS) && (cmd_reg == nfre_pkg::CMD_PROGRAM)
                           && (res_now.status == nfre_pkg::ST_OK));
    assign mem_waddr = (state_reg == S_ERASE) ? ers_addr_reg : ADDR_W'(addr_reg);
    assign mem_wdata = (state_reg == S_ERASE) ? nfre_pkg::ERASED_BYTE : val_reg;

    // Advance the sequencer
    always_comb
    begin
        state_next       = state_reg;
        window_base_next = window_base_reg;
        ers_addr_next    = ers_addr_reg;
        cnt_next         = cnt_reg;
        hold_next        = hold_reg;
        if (state_reg != S_HOLD)
        begin
            hold_next = res_now;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                if ((cmd_reg == nfre_pkg::CMD_MAP) && !map_fail)
                begin
                    window_base_next = map_base[ADDR_W-1:0];
                end
                if (erase_start)
                begin
                    state_next    = S_ERASE;
                    ers_addr_next = window_base_reg;
                    cnt_next      = '0;
                end
                else
                begin
                    state_next = res_take ? S_IDLE : S_HOLD;
                end
            end
            S_ERASE:
            begin
                ers_addr_next = ers_addr_reg + ADDR_W'(1);
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_last)
                begin
                    state_next = res_take ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_base_reg <= '0;
            ers_addr_reg    <= '0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            window_base_reg <= window_base_next;
            ers_addr_reg    <= ers_addr_next;
            cnt_reg         <= cnt_next;
        end
    end

    // Capture the request payload and the held result
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (accept)
        begin
            cmd_reg  <= nfre_pkg::cmd_t'(cmd);
            blk_reg  <= block_index;
            win_reg  <= window_index;
            addr_reg <= byte_address;
            val_reg  <= program_byte;
        end
    end

    // A taken request is always looked up in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_ACCESS))
        else $error("accepted request did not reach the access step");

    // The window base never points past the device end
    assert property (@(posedge clk) disable iff (!rst_n)
        window_base_reg < ADDR_W'(TOTAL_BYTES - 1) || window_base_reg == ADDR_W'(TOTAL_BYTES - 1))
        else $error("window base beyond device end");

    // An erase only walks addresses inside the device
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERASE) |-> (CMP_W'(ers_addr_reg) < CMP_W'(TOTAL_BYTES)))
        else $error("erase walked past device end");

    // A program write only clears bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg == S_ACCESS)) |-> ((~mem_rdata & mem_wdata) == 8'h00))
        else $error("program write would set a cleared bit");

endmodule : nfre_seq
`default_nettype wire
